// ----- src/assert_macros.svh -----
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge, including during reset
`define AST_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// checked only while out of reset
`define AST_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

// ----- src/bdwu_pkg.sv -----
`default_nettype none

package bdwu_pkg;

    // sizes
    localparam int MAX_NODES  = 32;
    localparam int MAX_INPUTS = 16;
    localparam int MAX_ACTIVE = 16;
    localparam int NSLOTS     = 1 + MAX_INPUTS + MAX_NODES;
    localparam int NENT       = MAX_NODES * NSLOTS;
    localparam int ENT_W      = $clog2(NENT);
    localparam int LIST_W     = $clog2(MAX_ACTIVE);

    // opcodes
    localparam logic [3:0] OP_NODE    = 4'd0;
    localparam logic [3:0] OP_LINK    = 4'd1;
    localparam logic [3:0] OP_ACT     = 4'd2;
    localparam logic [3:0] OP_ERR     = 4'd3;
    localparam logic [3:0] OP_ACTIVE  = 4'd4;
    localparam logic [3:0] OP_COMPUTE = 4'd5;
    localparam logic [3:0] OP_RCHG    = 4'd6;
    localparam logic [3:0] OP_RDEL    = 4'd7;
    localparam logic [3:0] OP_CLEAR   = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // activation function codes
    localparam logic [1:0] FN_LOG  = 2'd0;
    localparam logic [1:0] FN_TANH = 2'd1;
    localparam logic [1:0] FN_LIN  = 2'd2;
    localparam logic [1:0] FN_NONE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_INPUT_COUNT = 2'd1;
    localparam logic [1:0] CFG_CROSS_ENT   = 2'd2;
    localparam logic [1:0] CFG_LOCALIST    = 2'd3;

    // q16.16 constants
    localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;

    // command word
    typedef struct packed {
        logic [3:0]         opcode;
        logic [4:0]         node_index;
        logic [5:0]         source_index;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic [1:0]         func_code;
        logic               is_target_node;
        logic               link_present;
        logic               link_recurrent;
    } t_cmd;

    // result word
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } t_result;

    // saturated value with overflow flag
    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } t_sat;

    function automatic t_sat f_clamp(input logic signed [63:0] v);
        t_sat r;
        if (v > 64'sd2147483647) begin
            r.ovf = 1'b1;
            r.val = 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r.ovf = 1'b1;
            r.val = 32'sh8000_0000;
        end else begin
            r.ovf = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    function automatic t_sat f_qadd(input logic signed [31:0] a, input logic signed [31:0] b);
        return f_clamp(64'(a) + 64'(b));
    endfunction

    function automatic t_sat f_qsub(input logic signed [31:0] a, input logic signed [31:0] b);
        return f_clamp(64'(a) - 64'(b));
    endfunction

    // round half up, floor by 2^16, saturate
    function automatic t_sat f_round(input logic signed [63:0] p);
        return f_clamp((p + 64'sd32768) >>> 16);
    endfunction

endpackage

`default_nettype wire

// ----- src/backprop_delta_weight_update.sv -----
`default_nettype none

// Backprop delta and weight-change engine, signed Q16.16 with saturation.
// A command is taken when start is high and busy is low; its single result
// word appears on o_result for exactly one cycle with o_done high and cannot
// be held off. Load commands (node, link, activation, error, active input)
// give their result from the S_EXEC state, reads from S_RSP after it. Clear
// sweeps the change store one entry a cycle. After reset the block runs a
// clearing pass over every entry of the link-flag and change stores with
// busy high; configuration writes are taken throughout. Compute walks
// nodes and connections with one shared 32x32 multiplier and one read port
// per memory: first the output deltas node by node, then the hidden deltas
// over each node's downstream links, then the weight changes over each
// node's source slots.
module backprop_delta_weight_update (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire bdwu_pkg::t_cmd     i_cmd,
    output logic                    busy,
    output logic                    o_done,
    output bdwu_pkg::t_result       o_result,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [5:0]         i_cfg_data
);
    import bdwu_pkg::*;

`include "assert_macros.svh"

    // sequencer codes
    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_EXEC   = 5'd2;
    localparam logic [4:0] S_RSP    = 5'd3;
    localparam logic [4:0] S_CLR8   = 5'd4;
    localparam logic [4:0] S_P1_RD  = 5'd5;
    localparam logic [4:0] S_P1_EV  = 5'd6;
    localparam logic [4:0] S_P1_NX  = 5'd7;
    localparam logic [4:0] S_SL0    = 5'd8;
    localparam logic [4:0] S_SL1    = 5'd9;
    localparam logic [4:0] S_SL2    = 5'd10;
    localparam logic [4:0] S_SL3    = 5'd11;
    localparam logic [4:0] S_DM     = 5'd12;
    localparam logic [4:0] S_DW     = 5'd13;
    localparam logic [4:0] S_P2_RD  = 5'd14;
    localparam logic [4:0] S_P2_EV  = 5'd15;
    localparam logic [4:0] S_P2_JR  = 5'd16;
    localparam logic [4:0] S_P2_JM  = 5'd17;
    localparam logic [4:0] S_P2_JA  = 5'd18;
    localparam logic [4:0] S_P2_FIN = 5'd19;
    localparam logic [4:0] S_P2_NX  = 5'd20;
    localparam logic [4:0] S_P3_RD  = 5'd21;
    localparam logic [4:0] S_P3_D   = 5'd22;
    localparam logic [4:0] S_C_RD   = 5'd23;
    localparam logic [4:0] S_C_CK   = 5'd24;
    localparam logic [4:0] S_C_AC   = 5'd25;
    localparam logic [4:0] S_P3_NX  = 5'd26;
    localparam logic [4:0] S_DONE   = 5'd27;

    // localist source groups
    localparam logic [1:0] SUB_BIAS = 2'd0;
    localparam logic [1:0] SUB_LIST = 2'd1;
    localparam logic [1:0] SUB_NODE = 2'd2;

    // configuration
    logic [5:0] r_node_count;
    logic [4:0] r_input_count;
    logic       r_ce;
    logic       r_loc;

    // control and datapath registers
    logic [4:0]                r_state, n_state;
    t_cmd                      r_cmd, n_cmd;
    logic [4:0]                r_i, n_i;
    logic [5:0]                r_j, n_j;
    logic [4:0]                r_k, n_k;
    logic [1:0]                r_sub, n_sub;
    logic                      r_ph, n_ph;
    logic [1:0]                r_fn, n_fn;
    logic signed [31:0]        r_z, n_z;
    logic signed [31:0]        r_x, n_x;
    logic signed [31:0]        r_s, n_s;
    logic signed [31:0]        r_d, n_d;
    logic signed [31:0]        r_c, n_c;
    logic signed [37:0]        r_acc, n_acc;
    logic [5:0]                r_slot, n_slot;
    logic                      r_sat, n_sat;
    logic [ENT_W-1:0]          r_clr, n_clr;
    logic                      r_done, n_done;
    t_result                   r_res, n_res;
    logic [MAX_NODES-1:0][2:0] r_modes, n_modes;
    logic [MAX_ACTIVE-1:0][4:0] r_alist, n_alist;
    logic [4:0]                r_acnt, n_acnt;
    logic signed [63:0]        r_prod;

    // valid bits for the small reset-cleared stores
    logic [NSLOTS-1:0]    r_av;
    logic [MAX_NODES-1:0] r_dv;
    logic [MAX_NODES-1:0] r_tv;

    // memory ports
    logic                     w_we, f_we, c_we, a_we, d_we, t_we;
    logic [ENT_W-1:0]         lk_wa, lk_ra, c_wa, c_ra;
    logic signed [31:0]       w_wd, c_wd, d_wd, t_wd;
    logic [1:0]               f_wd;
    logic [5:0]               a_wa, a_ra;
    logic [63:0]              a_wd;
    logic [4:0]               d_wa, d_ra, t_wa, t_ra;
    logic signed [31:0]       r_w_q, r_c_q, r_d_q, r_t_q;
    logic [1:0]               r_lf_q;
    logic [63:0]              r_a_q;
    logic                     r_av_q, r_dv_q, r_tv_q;

    // multiplier operands
    logic signed [31:0] mul_a, mul_b;

    // derived values
    logic [5:0]         nn, np, nt;
    logic [4:0]         ni;
    logic               slot_ok;
    logic [ENT_W-1:0]   row_i, row_j, row_nd;
    logic signed [31:0] a_cur, a_prev, d_rd, t_rd;
    t_sat               sub1, add1, mul_res, q_tmp, q_acc;
    logic [4:0]         le;
    logic [5:0]         slot;
    logic               use_cur;
    logic [5:0]         adv_j;
    logic [4:0]         adv_k;
    logic [1:0]         adv_sub;

    // clamped counts and slot layout
    assign nn = (r_node_count > 6'(MAX_NODES)) ? 6'(MAX_NODES) : r_node_count;
    assign ni = (r_input_count > 5'(MAX_INPUTS)) ? 5'(MAX_INPUTS) : r_input_count;
    assign np = 6'(ni) + 6'd1;
    assign nt = np + nn;
    assign slot_ok = r_cmd.source_index < 6'(NSLOTS);
    assign row_i  = ENT_W'(r_i) * ENT_W'(NSLOTS);
    assign row_j  = ENT_W'(r_j[4:0]) * ENT_W'(NSLOTS);
    assign row_nd = ENT_W'(r_cmd.node_index) * ENT_W'(NSLOTS);

    // read data with valid masking
    assign a_cur  = r_av_q ? r_a_q[31:0]  : 32'sd0;
    assign a_prev = r_av_q ? r_a_q[63:32] : 32'sd0;
    assign d_rd   = r_dv_q ? r_d_q : 32'sd0;
    assign t_rd   = r_tv_q ? r_t_q : 32'sd0;

    // slope factors and rounded product
    assign sub1    = f_qsub(Q_ONE, r_z);
    assign add1    = f_qadd(Q_ONE, r_z);
    assign mul_res = f_round(r_prod);
    assign q_acc   = r_ce ? f_qadd(r_c, mul_res.val) : f_qsub(r_c, mul_res.val);
    assign le      = r_alist[r_k[LIST_W-1:0]];

    // next source position in the change pass
    always_comb begin
        adv_j   = r_j;
        adv_k   = r_k;
        adv_sub = r_sub;
        if (!r_loc) begin
            adv_j = r_j + 6'd1;
        end else begin
            unique case (r_sub)
                SUB_BIAS: begin
                    adv_sub = SUB_LIST;
                    adv_k   = 5'd0;
                end
                SUB_LIST: adv_k = r_k + 5'd1;
                default:  adv_j = r_j + 6'd1;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_sub   = r_sub;
        n_ph    = r_ph;
        n_fn    = r_fn;
        n_z     = r_z;
        n_x     = r_x;
        n_s     = r_s;
        n_d     = r_d;
        n_c     = r_c;
        n_acc   = r_acc;
        n_slot  = r_slot;
        n_sat   = r_sat;
        n_clr   = r_clr;
        n_done  = 1'b0;
        n_res   = r_res;
        n_modes = r_modes;
        n_alist = r_alist;
        n_acnt  = r_acnt;
        w_we = 1'b0; f_we = 1'b0; c_we = 1'b0; a_we = 1'b0; d_we = 1'b0; t_we = 1'b0;
        lk_wa = '0; lk_ra = '0; c_wa = '0; c_ra = '0;
        w_wd = r_cmd.value_a; f_wd = 2'b00; c_wd = 32'sd0;
        a_wa = '0; a_ra = '0; a_wd = {r_cmd.value_b, r_cmd.value_a};
        d_wa = r_i; d_ra = '0; d_wd = 32'sd0;
        t_wa = r_cmd.node_index; t_ra = '0; t_wd = r_cmd.value_b;
        mul_a = 32'sd0;
        mul_b = 32'sd0;
        q_tmp = '0;
        slot = 6'd0;
        use_cur = 1'b0;

        unique case (r_state)
            // clearing pass after reset
            S_CLR: begin
                c_we  = 1'b1;
                c_wa  = r_clr;
                f_we  = 1'b1;
                lk_wa = r_clr;
                if (r_clr == ENT_W'(NENT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_done           = 1'b1;
                n_res.read_value = 32'sd0;
                n_res.status     = ST_OK;
                n_state          = S_IDLE;
                unique case (r_cmd.opcode)
                    OP_NODE: begin
                        n_modes[r_cmd.node_index] = {r_cmd.is_target_node, r_cmd.func_code};
                    end
                    OP_LINK: begin
                        if (slot_ok) begin
                            w_we  = 1'b1;
                            f_we  = 1'b1;
                            lk_wa = row_nd + ENT_W'(r_cmd.source_index);
                            f_wd  = {r_cmd.link_recurrent, r_cmd.link_present};
                        end else begin
                            n_res.status = ST_RANGE;
                        end
                    end
                    OP_ACT: begin
                        if (slot_ok) begin
                            a_we = 1'b1;
                            a_wa = r_cmd.source_index;
                        end else begin
                            n_res.status = ST_RANGE;
                        end
                    end
                    OP_ERR: begin
                        d_we = 1'b1;
                        d_wa = r_cmd.node_index;
                        d_wd = r_cmd.value_a;
                        t_we = 1'b1;
                    end
                    OP_ACTIVE: begin
                        if (r_cmd.source_index >= 6'd1 &&
                            r_cmd.source_index <= 6'(MAX_INPUTS) &&
                            r_acnt < 5'(MAX_ACTIVE)) begin
                            n_alist[r_acnt[LIST_W-1:0]] = r_cmd.source_index[4:0];
                            n_acnt = r_acnt + 5'd1;
                        end else begin
                            n_res.status = ST_RANGE;
                        end
                    end
                    OP_COMPUTE: begin
                        n_sat = 1'b0;
                        if (nn != 6'd0) begin
                            n_done  = 1'b0;
                            n_i     = 5'd0;
                            n_state = S_P1_RD;
                        end
                    end
                    OP_RCHG: begin
                        if (slot_ok) begin
                            c_ra    = row_nd + ENT_W'(r_cmd.source_index);
                            n_done  = 1'b0;
                            n_state = S_RSP;
                        end else begin
                            n_res.status = ST_RANGE;
                        end
                    end
                    OP_RDEL: begin
                        d_ra    = r_cmd.node_index;
                        n_done  = 1'b0;
                        n_state = S_RSP;
                    end
                    OP_CLEAR: begin
                        n_acnt  = 5'd0;
                        n_clr   = '0;
                        n_done  = 1'b0;
                        n_state = S_CLR8;
                    end
                    default: begin
                    end
                endcase
            end

            // read response
            S_RSP: begin
                n_done           = 1'b1;
                n_res.status     = ST_OK;
                n_res.read_value = (r_cmd.opcode == OP_RCHG) ? r_c_q : d_rd;
                n_state          = S_IDLE;
            end

            // change store sweep for clear
            S_CLR8: begin
                c_we = 1'b1;
                c_wa = r_clr;
                if (r_clr == ENT_W'(NENT - 1)) begin
                    n_done           = 1'b1;
                    n_res.read_value = 32'sd0;
                    n_res.status     = ST_OK;
                    n_state          = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            // output deltas
            S_P1_RD: begin
                a_ra    = np + 6'(r_i);
                d_ra    = r_i;
                t_ra    = r_i;
                n_state = S_P1_EV;
            end

            S_P1_EV: begin
                if (!r_modes[r_i][2] || r_modes[r_i][1]) begin
                    n_state = S_P1_NX;
                end else if (r_modes[r_i][1:0] == FN_LOG && r_ce) begin
                    q_tmp   = f_qsub(t_rd, a_cur);
                    d_we    = 1'b1;
                    d_wd    = q_tmp.val;
                    n_sat   = r_sat | q_tmp.ovf;
                    n_state = S_P1_NX;
                end else begin
                    n_z     = a_cur;
                    n_x     = d_rd;
                    n_fn    = r_modes[r_i][1:0];
                    n_ph    = 1'b0;
                    n_state = S_SL0;
                end
            end

            S_P1_NX: begin
                if (r_i == 5'(nn - 6'd1)) begin
                    n_state = S_P2_RD;
                end else begin
                    n_i     = r_i + 5'd1;
                    n_state = S_P1_RD;
                end
            end

            // activation slope, then delta times slope
            S_SL0: begin
                if (r_fn == FN_LOG) begin
                    mul_a = r_z;
                    mul_b = sub1.val;
                    n_sat = r_sat | sub1.ovf;
                end else begin
                    mul_a = Q_HALF;
                    mul_b = add1.val;
                    n_sat = r_sat | add1.ovf;
                end
                n_state = S_SL1;
            end

            S_SL1: begin
                n_s     = mul_res.val;
                n_sat   = r_sat | mul_res.ovf;
                n_state = (r_fn == FN_LOG) ? S_DM : S_SL2;
            end

            S_SL2: begin
                mul_a   = r_s;
                mul_b   = sub1.val;
                n_sat   = r_sat | sub1.ovf;
                n_state = S_SL3;
            end

            S_SL3: begin
                n_s     = mul_res.val;
                n_sat   = r_sat | mul_res.ovf;
                n_state = S_DM;
            end

            S_DM: begin
                mul_a   = r_x;
                mul_b   = r_s;
                n_state = S_DW;
            end

            S_DW: begin
                d_we    = 1'b1;
                d_wd    = mul_res.val;
                n_sat   = r_sat | mul_res.ovf;
                n_state = r_ph ? S_P2_NX : S_P1_NX;
            end

            // hidden deltas, highest node first
            S_P2_RD: begin
                a_ra    = np + 6'(r_i);
                n_state = S_P2_EV;
            end

            S_P2_EV: begin
                if (r_modes[r_i][2]) begin
                    n_state = S_P2_NX;
                end else begin
                    n_z     = a_cur;
                    n_fn    = r_modes[r_i][1:0];
                    n_acc   = '0;
                    n_j     = 6'(r_i) + 6'd1;
                    n_state = S_P2_JR;
                end
            end

            S_P2_JR: begin
                if (r_j >= nn) begin
                    n_state = S_P2_FIN;
                end else begin
                    lk_ra   = row_j + ENT_W'(np) + ENT_W'(r_i);
                    d_ra    = r_j[4:0];
                    n_state = S_P2_JM;
                end
            end

            S_P2_JM: begin
                if (r_lf_q[0]) begin
                    mul_a   = r_w_q;
                    mul_b   = d_rd;
                    n_state = S_P2_JA;
                end else begin
                    n_j     = r_j + 6'd1;
                    n_state = S_P2_JR;
                end
            end

            S_P2_JA: begin
                n_acc   = r_acc + 38'(mul_res.val);
                n_sat   = r_sat | mul_res.ovf;
                n_j     = r_j + 6'd1;
                n_state = S_P2_JR;
            end

            S_P2_FIN: begin
                q_tmp = f_clamp(64'(r_acc));
                n_sat = r_sat | q_tmp.ovf;
                unique case (r_fn)
                    FN_LOG, FN_TANH: begin
                        n_x     = q_tmp.val;
                        n_ph    = 1'b1;
                        n_state = S_SL0;
                    end
                    FN_LIN: begin
                        d_we    = 1'b1;
                        d_wd    = q_tmp.val;
                        n_state = S_P2_NX;
                    end
                    default: begin
                        d_we    = 1'b1;
                        d_wd    = 32'sd0;
                        n_state = S_P2_NX;
                    end
                endcase
            end

            S_P2_NX: begin
                if (r_i == 5'd0) begin
                    n_state = S_P3_RD;
                end else begin
                    n_i     = r_i - 5'd1;
                    n_state = S_P2_RD;
                end
            end

            // weight changes, node by node
            S_P3_RD: begin
                d_ra    = r_i;
                n_state = S_P3_D;
            end

            S_P3_D: begin
                n_d     = d_rd;
                n_j     = 6'd0;
                n_k     = 5'd0;
                n_sub   = SUB_BIAS;
                n_state = S_C_RD;
            end

            S_C_RD: begin
                n_state = S_C_CK;
                if (!r_loc) begin
                    slot = r_j;
                    if (r_j >= nt) begin
                        n_state = S_P3_NX;
                    end
                end else begin
                    unique case (r_sub)
                        SUB_BIAS: slot = 6'd0;
                        SUB_LIST: begin
                            if (r_k >= r_acnt) begin
                                n_sub   = SUB_NODE;
                                n_j     = 6'd0;
                                n_state = S_C_RD;
                            end else if (le >= 5'd1 && le <= ni) begin
                                slot = 6'(le);
                            end else begin
                                n_k     = r_k + 5'd1;
                                n_state = S_C_RD;
                            end
                        end
                        default: begin
                            slot = np + r_j;
                            if (r_j >= nn) begin
                                n_state = S_P3_NX;
                            end
                        end
                    endcase
                end
                lk_ra  = row_i + ENT_W'(slot);
                c_ra   = row_i + ENT_W'(slot);
                a_ra   = slot;
                n_slot = slot;
            end

            S_C_CK: begin
                if (!r_lf_q[0]) begin
                    n_j     = adv_j;
                    n_k     = adv_k;
                    n_sub   = adv_sub;
                    n_state = S_C_RD;
                end else if (r_loc && r_sub != SUB_NODE) begin
                    // bias and listed inputs change by the delta itself
                    q_tmp   = r_ce ? f_qadd(r_c_q, r_d) : f_qsub(r_c_q, r_d);
                    c_we    = 1'b1;
                    c_wa    = row_i + ENT_W'(r_slot);
                    c_wd    = q_tmp.val;
                    n_sat   = r_sat | q_tmp.ovf;
                    n_j     = adv_j;
                    n_k     = adv_k;
                    n_sub   = adv_sub;
                    n_state = S_C_RD;
                end else begin
                    if (r_loc) begin
                        use_cur = r_j < 6'(r_i);
                    end else begin
                        use_cur = (7'(r_slot) < 7'(np) + 7'(r_i)) && !r_lf_q[1];
                    end
                    mul_a   = use_cur ? a_cur : a_prev;
                    mul_b   = r_d;
                    n_c     = r_c_q;
                    n_state = S_C_AC;
                end
            end

            S_C_AC: begin
                c_we    = 1'b1;
                c_wa    = row_i + ENT_W'(r_slot);
                c_wd    = q_acc.val;
                n_sat   = r_sat | mul_res.ovf | q_acc.ovf;
                n_j     = adv_j;
                n_k     = adv_k;
                n_sub   = adv_sub;
                n_state = S_C_RD;
            end

            S_P3_NX: begin
                if (r_i == 5'(nn - 6'd1)) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + 5'd1;
                    n_state = S_P3_RD;
                end
            end

            S_DONE: begin
                n_done           = 1'b1;
                n_res.read_value = 32'sd0;
                n_res.status     = r_sat ? ST_SAT : ST_OK;
                n_state          = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_clr         <= '0;
            r_done        <= 1'b0;
            r_modes       <= '0;
            r_acnt        <= 5'd0;
            r_av          <= '0;
            r_dv          <= '0;
            r_tv          <= '0;
            r_sat         <= 1'b0;
            r_node_count  <= 6'd1;
            r_input_count <= 5'd0;
            r_ce          <= 1'b0;
            r_loc         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
            r_modes <= n_modes;
            r_acnt  <= n_acnt;
            r_sat   <= n_sat;
            if (a_we) begin
                r_av[a_wa] <= 1'b1;
            end
            if (d_we) begin
                r_dv[d_wa] <= 1'b1;
            end
            if (t_we) begin
                r_tv[t_wa] <= 1'b1;
            end
            // configuration write
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NODE_COUNT:  r_node_count  <= i_cfg_data;
                    CFG_INPUT_COUNT: r_input_count <= i_cfg_data[4:0];
                    CFG_CROSS_ENT:   r_ce          <= i_cfg_data[0];
                    default:         r_loc         <= i_cfg_data[0];
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_sub   <= n_sub;
        r_ph    <= n_ph;
        r_fn    <= n_fn;
        r_z     <= n_z;
        r_x     <= n_x;
        r_s     <= n_s;
        r_d     <= n_d;
        r_c     <= n_c;
        r_acc   <= n_acc;
        r_slot  <= n_slot;
        r_res   <= n_res;
        r_alist <= n_alist;
        r_prod  <= mul_a * mul_b;
    end

    // weight store
    logic signed [31:0] m_w [NENT];
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_w[lk_wa] <= w_wd;
        end
        r_w_q <= m_w[lk_ra];
    end

    // link flags, bit 0 present, bit 1 recurrent
    logic [1:0] m_f [NENT];
    always_ff @(posedge i_clk) begin
        if (f_we) begin
            m_f[lk_wa] <= f_wd;
        end
        r_lf_q <= m_f[lk_ra];
    end

    // change store
    logic signed [31:0] m_c [NENT];
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            m_c[c_wa] <= c_wd;
        end
        r_c_q <= m_c[c_ra];
    end

    // activations, previous over current
    logic [63:0] m_a [NSLOTS];
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            m_a[a_wa] <= a_wd;
        end
        r_a_q  <= m_a[a_ra];
        r_av_q <= r_av[a_ra];
    end

    // node deltas
    logic signed [31:0] m_d [MAX_NODES];
    always_ff @(posedge i_clk) begin
        if (d_we) begin
            m_d[d_wa] <= d_wd;
        end
        r_d_q  <= m_d[d_ra];
        r_dv_q <= r_dv[d_ra];
    end

    // node targets
    logic signed [31:0] m_t [MAX_NODES];
    always_ff @(posedge i_clk) begin
        if (t_we) begin
            m_t[t_wa] <= t_wd;
        end
        r_t_q  <= m_t[t_ra];
        r_tv_q <= r_tv[t_ra];
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // checks
    `AST_CLK(a_no_done_after_rst, !i_rst_n |=> !o_done, "result word right after reset")
    `AST_CLK_RST(a_done_idle, o_done |-> !busy, "result word while sequencer busy")
    `AST_CLK_RST(a_take_busy, (start && !busy) |=> busy, "accepted word did not start work")
    `AST_CLK_RST(a_list_bound, r_acnt <= 5'(MAX_ACTIVE), "active list count overrun")

endmodule

`default_nettype wire
